@@ hdl/cc20_pkg.sv @@
// Shared constants and a quarter-round index function for the ChaCha20 stream cipher unit.
// No dependencies.
`default_nettype none
package cc20_pkg;
  localparam int BlockBytes   = 64;
  localparam int DoubleRounds = 10;
  localparam int NumRegs      = 6;
  localparam int AddrW        = 6;

  localparam logic [2:0] RegKey0  = 3'd0;
  localparam logic [2:0] RegKey1  = 3'd1;
  localparam logic [2:0] RegKey2  = 3'd2;
  localparam logic [2:0] RegKey3  = 3'd3;
  localparam logic [2:0] RegNonce = 3'd4;
  localparam logic [2:0] RegStart = 3'd5;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  // Word indexes a, b, c, d for each of the eight quarter rounds of a double round.
  function automatic logic [15:0] qr_idx(input logic [2:0] q);
    logic [15:0] r;
    case (q)
      3'd0: r = {4'd0, 4'd4, 4'd8,  4'd12};
      3'd1: r = {4'd1, 4'd5, 4'd9,  4'd13};
      3'd2: r = {4'd2, 4'd6, 4'd10, 4'd14};
      3'd3: r = {4'd3, 4'd7, 4'd11, 4'd15};
      3'd4: r = {4'd0, 4'd5, 4'd10, 4'd15};
      3'd5: r = {4'd1, 4'd6, 4'd11, 4'd12};
      3'd6: r = {4'd2, 4'd7, 4'd8,  4'd13};
      default: r = {4'd3, 4'd4, 4'd9, 4'd14};
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ hdl/cc20_if.sv @@
// Valid/ready stream interfaces for the cipher's input and output bytes.
// No dependencies.
`default_nettype none
interface cc20_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface cc20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  modport source (output valid, out_byte, input ready);
  modport sink (input valid, out_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/cc20_core.sv @@
// Block function: one shared quarter-round unit, run in halves S_QA and S_QB.
// Depends on cc20_pkg.
`default_nettype none
module cc20_core
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DoubleRounds
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [511:0] init_i,
  output logic              done_o,
  output logic [511:0]      block_o
);
  localparam int RndW = $clog2(DOUBLE_ROUNDS + 1);

  typedef enum logic [1:0] {S_IDLE, S_QA, S_QB, S_ADD} state_e;

  state_e          state_q;
  logic [31:0]     w_q [16];
  logic [511:0]    init_q;
  logic [RndW-1:0] rnd_q;
  logic [2:0]      qr_q;
  logic [3:0]      add_q;
  logic [15:0]     idx;
  logic [3:0]      ia, ib, ic, id;
  logic [31:0]     a1, b1, c1, d1, a2, b2, c2, d2, t;

  assign idx = qr_idx(qr_q);
  assign ia = idx[15:12];
  assign ib = idx[11:8];
  assign ic = idx[7:4];
  assign id = idx[3:0];

  // Each cycle performs half a quarter round: two add/xor/rotate pairs.
  always_comb begin
    a1 = w_q[ia] + w_q[ib];
    t  = w_q[id] ^ a1;
    d1 = (state_q == S_QA) ? {t[15:0], t[31:16]} : {t[23:0], t[31:24]};
    c1 = w_q[ic] + d1;
    t  = w_q[ib] ^ c1;
    b1 = (state_q == S_QA) ? {t[19:0], t[31:20]} : {t[24:0], t[31:25]};
    a2 = a1;
    b2 = b1;
    c2 = c1;
    d2 = d1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
      init_q  <= '0;
      rnd_q   <= '0;
      qr_q    <= '0;
      add_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            for (int i = 0; i < 16; i++) w_q[i] <= init_i[32*i +: 32];
            // The input words are kept for the feed-forward at the end.
            init_q  <= init_i;
            rnd_q   <= '0;
            qr_q    <= '0;
            state_q <= S_QA;
          end
        end
        S_QA, S_QB: begin
          w_q[ia] <= a2;
          w_q[ib] <= b2;
          w_q[ic] <= c2;
          w_q[id] <= d2;
          if (state_q == S_QA) begin
            state_q <= S_QB;
          end else begin
            qr_q <= qr_q + 3'd1;
            if (qr_q == 3'd7) begin
              if (rnd_q == RndW'(DOUBLE_ROUNDS - 1)) begin
                add_q   <= '0;
                state_q <= S_ADD;
              end else begin
                rnd_q   <= rnd_q + 1'b1;
                state_q <= S_QA;
              end
            end else begin
              state_q <= S_QA;
            end
          end
        end
        S_ADD: begin
          // Feed-forward, one word per cycle through its own adder.
          w_q[add_q] <= w_q[add_q] + init_q[32*add_q +: 32];
          add_q <= add_q + 4'd1;
          if (add_q == 4'd15) begin
            done_o  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) block_o[32*i +: 32] = w_q[i];
  end
endmodule
`default_nettype wire

@@ hdl/chacha20_stream_cipher_unit.sv @@
// Top level of the ChaCha20 stream cipher unit (64-bit counter and nonce).
// Depends on cc20_pkg, cc20_if and cc20_core.
//
// Bytes arrive on the in channel with a last-byte flag; each request returns
// one byte on the out channel, data XOR keystream. The first byte of a message
// loads the block counter from the RegStart register. When a fresh 64-byte
// block is needed, the shared quarter-round unit runs each quarter round in
// halves, then the feed-forward adds run one word at a time; such a byte has
// its result once the block is done. Other bytes pass from acceptance through
// S_EMIT to the output register; in both cases the next request is taken
// once the byte's result is registered. The keystream is read straight from
// the core's working words, which hold a block until the next one is started.
// A request is accepted while an earlier result still waits in the output
// register; a stalled receiver holds out_byte and valid steady, and once a
// second request is held the input stalls as well. Reset clears control
// state, sets registers to their reset values (RegStart to 1) and leaves no
// result pending. Configuration goes through an APB port at byte address 8*i;
// the user must write it only while no request is in flight (not enforced).
`default_nettype none
module chacha20_stream_cipher_unit
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DoubleRounds
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  cc20_in_if.sink                in_if,
  cc20_out_if.source             out_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);
  typedef enum logic [1:0] {S_IDLE, S_GEN, S_EMIT} state_e;

  state_e       state_q;
  logic [63:0]  cfg_q [NumRegs];
  logic         active_q;
  logic [63:0]  ctr_q;
  logic [6:0]   pos_q;
  logic [7:0]   data_q;
  logic         last_q;
  logic         ovalid_q;
  logic [7:0]   obyte_q;
  logic         start;
  logic         done;
  logic [511:0] blk;
  logic [511:0] init;
  logic [63:0]  ctr_use;
  logic [2:0]   reg_idx;
  logic         wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr      = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (reg_idx < 3'(NumRegs)) prdata = cfg_q[reg_idx];
  end

  assign ctr_use = active_q ? ctr_q : cfg_q[RegStart];
  assign init = {cfg_q[RegNonce], ctr_use, cfg_q[RegKey3], cfg_q[RegKey2],
                 cfg_q[RegKey1], cfg_q[RegKey0], Sigma3, Sigma2, Sigma1, Sigma0};

  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid    = ovalid_q;
  assign out_if.out_byte = obyte_q;

  assign start = (state_q == S_IDLE) && in_if.valid && in_if.ready &&
                 (!active_q || pos_q[6]);

  cc20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .init_i  (init),
    .done_o  (done),
    .block_o (blk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) cfg_q[i] <= '0;
      cfg_q[RegStart] <= 64'd1;
      state_q  <= S_IDLE;
      active_q <= 1'b0;
      pos_q    <= 7'd64;
      ovalid_q <= 1'b0;
      ctr_q    <= '0;
      data_q   <= '0;
      last_q   <= 1'b0;
      obyte_q  <= '0;
    end else begin
      if (wr && reg_idx < 3'(NumRegs)) cfg_q[reg_idx] <= pwdata;
      if (ovalid_q && out_if.ready && state_q != S_EMIT) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            data_q <= in_if.data_byte;
            last_q <= in_if.last_byte;
            if (start) begin
              ctr_q   <= ctr_use + 64'd1;
              state_q <= S_GEN;
            end else begin
              state_q <= S_EMIT;
            end
          end
        end
        S_GEN: begin
          if (done) begin
            pos_q   <= 7'd0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Wait here while the previous result is still held by the receiver.
          if (!ovalid_q || out_if.ready) begin
            obyte_q  <= data_q ^ blk[8*pos_q[5:0] +: 8];
            ovalid_q <= 1'b1;
            pos_q    <= pos_q + 7'd1;
            active_q <= !last_q;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A result waits in S_EMIT while the output register is still occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && ovalid_q && !out_if.ready) |=> (state_q == S_EMIT))
    else $error("result overwritten before taken");
  // A block start, only from idle with a request accepted, leads to S_GEN.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == S_GEN))
    else $error("block generation did not begin");
  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_if.ready) |=> (ovalid_q && $stable(obyte_q)))
    else $error("stalled result changed");
`endif
endmodule
`default_nettype wire
